FILE: hw/rtl/ira_pkg.sv
// Shared types, codes and helpers for the integer to radix ASCII unit.
package ira_pkg;

    localparam int MAX_DIGITS_DEF = 22;
    localparam int PC_W           = 3;

    // Operand width codes; any other code means 64 bits
    localparam logic [1:0] WIDTH_16 = 2'd0;
    localparam logic [1:0] WIDTH_32 = 2'd1;

    // Radix codes; any other code means hexadecimal
    localparam logic [1:0] RADIX_OCT = 2'd0;
    localparam logic [1:0] RADIX_DEC = 2'd1;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_LOW_A = 8'h61;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    // Program step addresses
    localparam logic [PC_W-1:0] STEP_IDLE = 3'd0;
    localparam logic [PC_W-1:0] STEP_DIV  = 3'd1;
    localparam logic [PC_W-1:0] STEP_SIGN = 3'd2;
    localparam logic [PC_W-1:0] STEP_EMIT = 3'd3;
    localparam logic [PC_W-1:0] STEP_RET  = 3'd4;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_DIV,
        OP_SIGN,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_INPUT,
        C_DIV_AGAIN,
        C_MORE_DIGITS
    } cond_t;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } ctrl_word_t;

    // Sequencer to datapath
    typedef struct packed {
        op_t  op;
        logic fire;
    } ctrl_t;

    // Datapath to sequencer
    typedef struct packed {
        logic in_valid;
        logic out_free;
        logic neg;
        logic div_again;
        logic more_digits;
    } status_t;

    // Map a digit to its lower case ASCII character
    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] ch;
        if (d < 4'd10)
        begin
            ch = CHAR_ZERO + {4'b0000, d};
        end
        else
        begin
            ch = CHAR_LOW_A + {4'b0000, d} - 8'd10;
        end
        return ch;
    endfunction

endpackage

FILE: hw/rtl/ira_if.sv
// Handshake channels for the number input and the character output.
interface ira_num_if;
    logic        valid;
    logic        ready;
    logic [63:0] value;
    logic [1:0]  width_code;
    logic        signed_flag;
    logic [1:0]  radix_code;

    modport source (output valid, value, width_code, signed_flag, radix_code, input ready);
    modport sink   (input valid, value, width_code, signed_flag, radix_code, output ready);
endinterface

interface ira_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, char_code, last_char, input ready);
    modport sink   (input valid, char_code, last_char, output ready);
endinterface

FILE: hw/rtl/integer_to_radix_ascii_unit.sv
// Sequence: accept a number, divide out its digits (octal and hex by shifting, decimal by
// dividing each 16-bit chunk by ten, most significant chunk first), then a sign step that
// writes a '-' when negative, then emit the digit characters, most significant first, and return.
// Throughput: one number at a time; decimal conversion is the slowest, set by the 16-bit chunk divide-by-ten step.
// Output stalls hold the sign and emit steps. Reset clears the step counter, counts and
// valid flags; the digit store is not cleared and is always written before it is read.
module integer_to_radix_ascii_unit
#(
    parameter int MAX_DIGITS = ira_pkg::MAX_DIGITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    ira_num_if.sink    number,
    ira_char_if.source chars
);

    ira_pkg::ctrl_t   ctrl;
    ira_pkg::status_t status;

    ira_sequencer u_seq
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    ira_datapath #(.MAX_DIGITS(MAX_DIGITS)) u_dp
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .number (number),
        .chars  (chars),
        .ctrl   (ctrl),
        .status (status)
    );

endmodule

FILE: hw/rtl/ira_sequencer.sv
// Microcode program store, step counter and branch logic.
module ira_sequencer
(
    input  logic              clk,
    input  logic              rst_n,
    input  ira_pkg::status_t  status,
    output ira_pkg::ctrl_t    ctrl
);

    logic [ira_pkg::PC_W-1:0] pc_reg;
    logic [ira_pkg::PC_W-1:0] pc_next;
    ira_pkg::ctrl_word_t      word;
    logic                     need_out;
    logic                     stall;
    logic                     branch;

    // Program: wait for a word, divide out digits, sign, emit, return
    function automatic ira_pkg::ctrl_word_t rom_word(input logic [ira_pkg::PC_W-1:0] pc);
        ira_pkg::ctrl_word_t w;
        case (pc)
            ira_pkg::STEP_IDLE: w = '{ira_pkg::OP_LOAD, ira_pkg::C_NO_INPUT,    ira_pkg::STEP_IDLE};
            ira_pkg::STEP_DIV:  w = '{ira_pkg::OP_DIV,  ira_pkg::C_DIV_AGAIN,   ira_pkg::STEP_DIV};
            ira_pkg::STEP_SIGN: w = '{ira_pkg::OP_SIGN, ira_pkg::C_NEVER,       ira_pkg::STEP_IDLE};
            ira_pkg::STEP_EMIT: w = '{ira_pkg::OP_EMIT, ira_pkg::C_MORE_DIGITS, ira_pkg::STEP_EMIT};
            ira_pkg::STEP_RET:  w = '{ira_pkg::OP_NOP,  ira_pkg::C_ALWAYS,      ira_pkg::STEP_IDLE};
            default:            w = '{ira_pkg::OP_NOP,  ira_pkg::C_ALWAYS,      ira_pkg::STEP_IDLE};
        endcase
        return w;
    endfunction

    assign word = rom_word(pc_reg);

    // Hold an emit step, or a sign step for a negative number, while the output register is still occupied
    assign need_out = (word.op == ira_pkg::OP_EMIT) ||
                      ((word.op == ira_pkg::OP_SIGN) && status.neg);
    assign stall    = need_out && !status.out_free;

    // Evaluate the branch condition
    always_comb
    begin
        case (word.cond)
            ira_pkg::C_NEVER:       branch = 1'b0;
            ira_pkg::C_ALWAYS:      branch = 1'b1;
            ira_pkg::C_NO_INPUT:    branch = !status.in_valid;
            ira_pkg::C_DIV_AGAIN:   branch = status.div_again;
            ira_pkg::C_MORE_DIGITS: branch = status.more_digits;
            default:                branch = 1'b1;
        endcase
    end

    // Advance, jump or hold
    always_comb
    begin
        if (stall)
        begin
            pc_next = pc_reg;
        end
        else if (branch)
        begin
            pc_next = word.target;
        end
        else
        begin
            pc_next = pc_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= ira_pkg::STEP_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    assign ctrl.op   = word.op;
    assign ctrl.fire = !stall;

endmodule

FILE: hw/rtl/ira_datapath.sv
// Magnitude, digit division, digit store and character output register.
module ira_datapath
#(
    parameter int MAX_DIGITS = ira_pkg::MAX_DIGITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    ira_num_if.sink           number,
    ira_char_if.source        chars,
    input  ira_pkg::ctrl_t    ctrl,
    output ira_pkg::status_t  status
);

    localparam int CNT_W = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W = $clog2(MAX_DIGITS);

    // floor(x / 10) == (x * RECIP) >> 23 for every x below 10 * 2^16
    localparam logic [19:0] RECIP = 20'd838861;

    logic [63:0]      val_reg;
    logic [1:0]       radix_reg;
    logic             neg_reg;
    logic [1:0]       chunk_reg;
    logic [3:0]       rem_reg;
    logic [CNT_W-1:0] count_reg;
    logic [3:0]       store_mem [MAX_DIGITS];
    logic             out_valid_reg;
    logic [7:0]       out_char_reg;
    logic             out_last_reg;

    logic             load_fire;
    logic             div_fire;
    logic             sign_fire;
    logic             emit_fire;
    logic             out_free;

    logic [63:0]      masked;
    logic             sign_bit;
    logic             neg_next;
    logic [63:0]      mag_next;

    logic [15:0]      cur_chunk;
    logic [19:0]      dec_x;
    logic [39:0]      dec_prod;
    logic [15:0]      dec_q;
    logic [19:0]      dec_r_full;
    logic [63:0]      quot_next;
    logic [3:0]       digit;
    logic             digit_done;
    logic [CNT_W-1:0] count_dec;
    logic [IDX_W-1:0] rd_idx;

    assign number.ready = (ctrl.op == ira_pkg::OP_LOAD);
    assign load_fire    = ctrl.fire && (ctrl.op == ira_pkg::OP_LOAD) && number.valid;
    assign div_fire     = ctrl.fire && (ctrl.op == ira_pkg::OP_DIV);
    assign sign_fire    = ctrl.fire && (ctrl.op == ira_pkg::OP_SIGN) && neg_reg;
    assign emit_fire    = ctrl.fire && (ctrl.op == ira_pkg::OP_EMIT);
    assign out_free     = !out_valid_reg || chars.ready;

    // Trim to the operand width and take the magnitude
    always_comb
    begin
        case (number.width_code)
            ira_pkg::WIDTH_16:
            begin
                masked   = {48'b0, number.value[15:0]};
                sign_bit = number.value[15];
            end
            ira_pkg::WIDTH_32:
            begin
                masked   = {32'b0, number.value[31:0]};
                sign_bit = number.value[31];
            end
            default:
            begin
                masked   = number.value;
                sign_bit = number.value[63];
            end
        endcase
        neg_next = number.signed_flag && sign_bit;
        case (number.width_code)
            ira_pkg::WIDTH_16: mag_next = {48'b0, 16'(~masked[15:0] + 16'd1)};
            ira_pkg::WIDTH_32: mag_next = {32'b0, 32'(~masked[31:0] + 32'd1)};
            default:           mag_next = ~masked + 64'd1;
        endcase
        if (!neg_next)
        begin
            mag_next = masked;
        end
    end

    // Divide one 16-bit chunk by ten, most significant chunk first
    assign cur_chunk  = val_reg[{chunk_reg, 4'b0000} +: 16];
    assign dec_x      = {rem_reg, cur_chunk};
    assign dec_prod   = {20'b0, dec_x} * {20'b0, RECIP};
    assign dec_q      = dec_prod[38:23];
    assign dec_r_full = dec_x - {1'b0, dec_q, 3'b000} - {3'b000, dec_q, 1'b0};

    // Pick the quotient and digit for the current radix
    always_comb
    begin
        quot_next  = val_reg;
        digit      = val_reg[3:0];
        digit_done = 1'b1;
        case (radix_reg)
            ira_pkg::RADIX_OCT:
            begin
                quot_next = {3'b000, val_reg[63:3]};
                digit     = {1'b0, val_reg[2:0]};
            end
            ira_pkg::RADIX_DEC:
            begin
                quot_next[{chunk_reg, 4'b0000} +: 16] = dec_q;
                digit      = dec_r_full[3:0];
                digit_done = (chunk_reg == 2'd0);
            end
            default:
            begin
                quot_next = {4'b0000, val_reg[63:4]};
                digit     = val_reg[3:0];
            end
        endcase
    end

    assign count_dec = count_reg - 1'b1;
    assign rd_idx    = count_dec[IDX_W-1:0];

    assign status.in_valid    = number.valid;
    assign status.out_free    = out_free;
    assign status.neg         = neg_reg;
    assign status.div_again   = !digit_done || (quot_next != 64'd0);
    assign status.more_digits = (count_reg != CNT_W'(1));

    // Control and working registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg       <= '0;
            radix_reg     <= ira_pkg::RADIX_OCT;
            neg_reg       <= 1'b0;
            chunk_reg     <= 2'd3;
            rem_reg       <= 4'd0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // Load a new number
            if (load_fire)
            begin
                val_reg   <= mag_next;
                radix_reg <= number.radix_code;
                neg_reg   <= neg_next;
                chunk_reg <= 2'd3;
                rem_reg   <= 4'd0;
                count_reg <= '0;
            end
            // Advance one division step
            if (div_fire)
            begin
                val_reg <= quot_next;
                if (digit_done)
                begin
                    chunk_reg <= 2'd3;
                    rem_reg   <= 4'd0;
                    if (count_reg < CNT_W'(MAX_DIGITS))
                    begin
                        count_reg <= count_reg + 1'b1;
                    end
                end
                else
                begin
                    chunk_reg <= chunk_reg - 2'd1;
                    rem_reg   <= dec_r_full[3:0];
                end
            end
            // Drop one digit per emitted character
            if (emit_fire)
            begin
                count_reg <= count_dec;
            end
            // Fill or drain the output register
            if (sign_fire || emit_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (chars.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Digit store and output payload
    always_ff @(posedge clk)
    begin
        if (div_fire && digit_done && (count_reg < CNT_W'(MAX_DIGITS)))
        begin
            store_mem[count_reg[IDX_W-1:0]] <= digit;
        end
        if (sign_fire)
        begin
            out_char_reg <= ira_pkg::CHAR_MINUS;
            out_last_reg <= 1'b0;
        end
        else if (emit_fire)
        begin
            out_char_reg <= ira_pkg::digit_char(store_mem[rd_idx]);
            out_last_reg <= (count_reg == CNT_W'(1));
        end
    end

    assign chars.valid     = out_valid_reg;
    assign chars.char_code = out_char_reg;
    assign chars.last_char = out_last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_DIGITS))
        else $error("digit count beyond store depth");

    a_emit_has_digit: assert property (@(posedge clk) disable iff (!rst_n)
        emit_fire |-> (count_reg != '0))
        else $error("emit with no digit collected");

    a_out_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_fire || sign_fire) |-> (!out_valid_reg || chars.ready))
        else $error("output word overwritten while held");

    a_chunk_decimal_only: assert property (@(posedge clk) disable iff (!rst_n)
        (chunk_reg != 2'd3) |-> (radix_reg == ira_pkg::RADIX_DEC))
        else $error("chunk step outside decimal division");

endmodule
